>>> src/mke_pkg.sv
package mke_pkg;

	localparam int WEIGHT_BITS = 32;
	localparam int NUM_CLASSES = 12;
	localparam int IDX_BITS    = 4;
	localparam int NORM_BITS   = 20;
	localparam int SH_BITS     = $clog2(WEIGHT_BITS - NORM_BITS + 1);
	localparam int SUMV_BITS   = NORM_BITS + 4;
	localparam int A_BITS      = NORM_BITS + 5;
	localparam int B_BITS      = 14;
	localparam int DW_BITS     = 2 * (A_BITS - 1) + 4;
	localparam int SQW_BITS    = DW_BITS / 2;
	localparam int SQP_BITS    = 14;
	localparam int MUL_BITS    = SQW_BITS + 1;
	localparam int PROD_BITS   = 2 * MUL_BITS;
	localparam int NUM_BITS    = A_BITS + B_BITS + 3;
	localparam int DEN_BITS    = SQW_BITS + SQP_BITS;
	localparam int Q_BITS      = 17;
	localparam int DIV_BITS    = NUM_BITS + 15;
	localparam int IT_BITS     = 5;
	localparam int CAND_BITS   = 5;
	localparam int NUM_CAND    = 2 * NUM_CLASSES;
	localparam int SQ_ITERS    = DW_BITS / 2;
	localparam int DIV_ITERS   = Q_BITS;

	localparam logic [9:0] PROF_MAJ [NUM_CLASSES] = '{
		10'd635, 10'd223, 10'd348, 10'd233, 10'd438, 10'd409,
		10'd252, 10'd519, 10'd239, 10'd366, 10'd229, 10'd288};
	localparam logic [9:0] PROF_MIN [NUM_CLASSES] = '{
		10'd633, 10'd268, 10'd352, 10'd538, 10'd260, 10'd353,
		10'd254, 10'd475, 10'd398, 10'd269, 10'd334, 10'd317};
	localparam int SUM_MAJ = 4179;
	localparam int SUM_MIN = 4451;

	typedef enum logic [3:0] {
		S_IDLE, S_MAX, S_SHIFT, S_SUM, S_AVAL, S_DWMUL, S_DWACC, S_SQRT,
		S_NUMMUL, S_NUMACC, S_DENMUL, S_DENLD, S_DIV, S_PICK, S_DONE
	} state_t;

	// pitch mod 12 via reciprocal multiply, exact for 0..127
	function automatic logic [IDX_BITS-1:0] pitch_class(input logic [6:0] p);
		logic [12:0] prd;
		logic [3:0]  quo;
		logic [6:0]  rem;
		prd = 13'(p) * 13'd43;
		quo = prd[12:9];
		rem = p - 7'(quo) * 7'd12;
		return rem[IDX_BITS-1:0];
	endfunction

	// centered profile value 12*p - sum for rotation root
	function automatic logic signed [B_BITS-1:0] b_value(input logic minor,
			input logic [IDX_BITS-1:0] root, input logic [IDX_BITS-1:0] i);
		logic [IDX_BITS:0]   jw;
		logic [IDX_BITS-1:0] j;
		logic [9:0]          p;
		logic signed [B_BITS:0] r;
		if (i >= root)
			jw = {1'b0, i} - {1'b0, root};
		else
			jw = {1'b0, i} + (IDX_BITS+1)'(NUM_CLASSES) - {1'b0, root};
		j = jw[IDX_BITS-1:0];
		p = minor ? PROF_MIN[j] : PROF_MAJ[j];
		r = $signed((B_BITS+1)'(p) * (B_BITS+1)'(12))
			- $signed((B_BITS+1)'(minor ? SUM_MIN : SUM_MAJ));
		return r[B_BITS-1:0];
	endfunction

	function automatic logic [SQP_BITS-1:0] sqrt_dp(input logic minor);
		logic [31:0] acc;
		logic [31:0] x;
		logic [31:0] res;
		logic [31:0] bt;
		logic signed [31:0] b;
		acc = 32'd0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			b = 32'(b_value(minor, 4'd0, 4'(i)));
			acc = acc + 32'(b * b);
		end
		x = acc;
		res = 32'd0;
		for (int k = 15; k >= 0; k--) begin
			bt = 32'd1 << (2 * k);
			if (x >= res + bt) begin
				x = x - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
		end
		return res[SQP_BITS-1:0];
	endfunction

	localparam logic [SQP_BITS-1:0] SQRT_DP_MAJ = sqrt_dp(1'b0);
	localparam logic [SQP_BITS-1:0] SQRT_DP_MIN = sqrt_dp(1'b1);

endpackage

>>> src/musical_key_estimator.sv
// Note item: busy stays low, a note can be taken every cycle.
// End item with notes: after acceptance come max scan, shift, sum and centering,
// sum of squares, square root and the 24 root and mode candidates, then the
// result is loaded; busy meanwhile.
// End item with no notes: the search is skipped and S_DONE loads a zero result.
// done pulses one cycle with the result; the receiver cannot stall it.
// arst_n clears weights, note flag and sequencer at once.
module musical_key_estimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [6:0]  pitch,
	input  logic [15:0] duration,
	output logic        done,
	output logic [3:0]  root,
	output logic        is_minor,
	output logic        has_notes,
	output logic signed [15:0] score
);
	localparam logic [mke_pkg::IDX_BITS-1:0] LAST_IDX =
		mke_pkg::IDX_BITS'(mke_pkg::NUM_CLASSES - 1);

	mke_pkg::state_t state_q, state_d;

	logic [mke_pkg::WEIGHT_BITS-1:0] w_q [mke_pkg::NUM_CLASSES];
	logic seen_q;
	logic [mke_pkg::IDX_BITS-1:0]  idx_q;
	logic [mke_pkg::IT_BITS-1:0]   it_q;
	logic [mke_pkg::CAND_BITS-1:0] cand_q;
	logic [mke_pkg::WEIGHT_BITS-1:0] mx_q;
	logic [mke_pkg::SH_BITS-1:0]   sh_q;
	logic [mke_pkg::SUMV_BITS-1:0] sumv_q;
	logic signed [mke_pkg::A_BITS-1:0] a_q [mke_pkg::NUM_CLASSES];
	logic signed [mke_pkg::PROD_BITS-1:0] prod_s1;
	logic [mke_pkg::DW_BITS-1:0] dw_q, sqx_q, sqres_q, sqbit_q;
	logic signed [mke_pkg::NUM_BITS-1:0] num_q;
	logic [mke_pkg::DIV_BITS-1:0] rem_q, dsr_q;
	logic [mke_pkg::Q_BITS-1:0]   quo_q;
	logic signed [15:0] best_q;
	logic [3:0] best_root_q;
	logic best_minor_q;
	logic done_q;
	logic [3:0] root_q;
	logic is_minor_q, has_notes_q;
	logic signed [15:0] score_q;

	logic accept;
	logic [mke_pkg::IDX_BITS-1:0] pc;
	logic [mke_pkg::WEIGHT_BITS:0] wsum;
	logic [mke_pkg::WEIGHT_BITS-1:0] wshift;
	logic [mke_pkg::NORM_BITS-1:0] vcur;
	logic signed [mke_pkg::A_BITS-1:0] v_ext, a_new;
	logic signed [mke_pkg::MUL_BITS-1:0] mul_x, mul_y;
	logic signed [mke_pkg::PROD_BITS-1:0] prod;
	logic [mke_pkg::DW_BITS-1:0] dw_next, sq_try;
	logic signed [mke_pkg::NUM_BITS-1:0] num_mag;
	logic [3:0] cand_root;
	logic cand_minor;
	logic signed [mke_pkg::B_BITS-1:0] bval;
	logic signed [15:0] score_c;

	assign accept     = start && !busy;
	assign pc         = mke_pkg::pitch_class(pitch);
	assign wsum       = {1'b0, w_q[pc]} + (mke_pkg::WEIGHT_BITS+1)'(duration);
	assign wshift     = w_q[idx_q] >> sh_q;
	assign vcur       = wshift[mke_pkg::NORM_BITS-1:0];
	assign v_ext      = $signed(mke_pkg::A_BITS'(vcur));
	assign a_new      = (v_ext <<< 3) + (v_ext <<< 2) - $signed(mke_pkg::A_BITS'(sumv_q));
	assign cand_root  = cand_q[mke_pkg::CAND_BITS-1:1];
	assign cand_minor = cand_q[0];
	assign bval       = mke_pkg::b_value(cand_minor, cand_root, idx_q);
	assign prod       = mul_x * mul_y;
	assign dw_next    = dw_q + prod_s1[mke_pkg::DW_BITS-1:0];
	assign sq_try     = sqres_q + sqbit_q;
	assign num_mag    = (num_q < 0) ? -num_q : num_q;

	always_comb begin
		if (dw_q == '0)
			score_c = 16'sd0;
		else if (num_q < 0)
			score_c = (quo_q > 17'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, quo_q}));
		else
			score_c = (quo_q > 17'd32767) ? 16'sd32767 : $signed(quo_q[15:0]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mke_pkg::S_IDLE:   if (accept && kind) state_d = seen_q ? mke_pkg::S_MAX
				: mke_pkg::S_DONE;
			mke_pkg::S_MAX:    if (idx_q == LAST_IDX) state_d = mke_pkg::S_SHIFT;
			mke_pkg::S_SHIFT:  if (mx_q[mke_pkg::WEIGHT_BITS-1:mke_pkg::NORM_BITS] == '0)
				state_d = mke_pkg::S_SUM;
			mke_pkg::S_SUM:    if (idx_q == LAST_IDX) state_d = mke_pkg::S_AVAL;
			mke_pkg::S_AVAL:   if (idx_q == LAST_IDX) state_d = mke_pkg::S_DWMUL;
			mke_pkg::S_DWMUL:  state_d = mke_pkg::S_DWACC;
			mke_pkg::S_DWACC:  state_d = (idx_q == LAST_IDX) ? mke_pkg::S_SQRT
				: mke_pkg::S_DWMUL;
			mke_pkg::S_SQRT:   if (it_q == mke_pkg::IT_BITS'(mke_pkg::SQ_ITERS - 1))
				state_d = mke_pkg::S_NUMMUL;
			mke_pkg::S_NUMMUL: state_d = mke_pkg::S_NUMACC;
			mke_pkg::S_NUMACC: state_d = (idx_q == LAST_IDX) ? mke_pkg::S_DENMUL
				: mke_pkg::S_NUMMUL;
			mke_pkg::S_DENMUL: state_d = mke_pkg::S_DENLD;
			mke_pkg::S_DENLD:  state_d = mke_pkg::S_DIV;
			mke_pkg::S_DIV:    if (it_q == mke_pkg::IT_BITS'(mke_pkg::DIV_ITERS - 1))
				state_d = mke_pkg::S_PICK;
			mke_pkg::S_PICK:   state_d = (cand_q == mke_pkg::CAND_BITS'(mke_pkg::NUM_CAND - 1))
				? mke_pkg::S_DONE : mke_pkg::S_NUMMUL;
			mke_pkg::S_DONE:   state_d = mke_pkg::S_IDLE;
			default:           state_d = mke_pkg::S_IDLE;
		endcase
	end

	// outputs: busy and multiplier operand select
	always_comb begin
		busy  = (state_q != mke_pkg::S_IDLE);
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			mke_pkg::S_DWMUL: begin
				mul_x = mke_pkg::MUL_BITS'(a_q[idx_q]);
				mul_y = mke_pkg::MUL_BITS'(a_q[idx_q]);
			end
			mke_pkg::S_NUMMUL: begin
				mul_x = mke_pkg::MUL_BITS'(a_q[idx_q]);
				mul_y = mke_pkg::MUL_BITS'(bval);
			end
			mke_pkg::S_DENMUL: begin
				mul_x = $signed(mke_pkg::MUL_BITS'(sqres_q[mke_pkg::SQW_BITS-1:0]));
				mul_y = $signed(mke_pkg::MUL_BITS'(cand_minor ? mke_pkg::SQRT_DP_MIN
					: mke_pkg::SQRT_DP_MAJ));
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mke_pkg::S_IDLE;
			for (int i = 0; i < mke_pkg::NUM_CLASSES; i++) w_q[i] <= '0;
			seen_q  <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			it_q    <= '0;
			cand_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				mke_pkg::S_IDLE: begin
					idx_q  <= '0;
					mx_q   <= '0;
					sh_q   <= '0;
					sumv_q <= '0;
					if (accept && !kind) begin
						w_q[pc] <= wsum[mke_pkg::WEIGHT_BITS] ? '1
							: wsum[mke_pkg::WEIGHT_BITS-1:0];
						seen_q  <= 1'b1;
					end
				end
				mke_pkg::S_MAX: begin
					if (w_q[idx_q] > mx_q) mx_q <= w_q[idx_q];
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				end
				mke_pkg::S_SHIFT: begin
					if (mx_q[mke_pkg::WEIGHT_BITS-1:mke_pkg::NORM_BITS] != '0) begin
						mx_q <= mx_q >> 1;
						sh_q <= sh_q + 1'b1;
					end
				end
				mke_pkg::S_SUM: begin
					sumv_q <= sumv_q + mke_pkg::SUMV_BITS'(vcur);
					idx_q  <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				end
				mke_pkg::S_AVAL: begin
					a_q[idx_q] <= a_new;
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
					dw_q  <= '0;
				end
				mke_pkg::S_DWMUL:  prod_s1 <= prod;
				mke_pkg::S_DWACC: begin
					dw_q  <= dw_next;
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
					sqx_q   <= dw_next;
					sqres_q <= '0;
					sqbit_q <= mke_pkg::DW_BITS'(1) << (mke_pkg::DW_BITS - 2);
					it_q    <= '0;
				end
				mke_pkg::S_SQRT: begin
					if (sqx_q >= sq_try) begin
						sqx_q   <= sqx_q - sq_try;
						sqres_q <= (sqres_q >> 1) + sqbit_q;
					end else begin
						sqres_q <= sqres_q >> 1;
					end
					sqbit_q <= sqbit_q >> 2;
					it_q    <= it_q + 1'b1;
					cand_q  <= '0;
					num_q   <= '0;
				end
				mke_pkg::S_NUMMUL: prod_s1 <= prod;
				mke_pkg::S_NUMACC: begin
					num_q <= num_q + $signed(prod_s1[mke_pkg::NUM_BITS-1:0]);
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				end
				mke_pkg::S_DENMUL: prod_s1 <= prod;
				mke_pkg::S_DENLD: begin
					rem_q <= {num_mag, 15'd0};
					dsr_q <= mke_pkg::DIV_BITS'(prod_s1[mke_pkg::DEN_BITS-1:0]) << 16;
					quo_q <= '0;
					it_q  <= '0;
				end
				mke_pkg::S_DIV: begin
					if (rem_q >= dsr_q) begin
						rem_q <= rem_q - dsr_q;
						quo_q <= {quo_q[mke_pkg::Q_BITS-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[mke_pkg::Q_BITS-2:0], 1'b0};
					end
					dsr_q <= dsr_q >> 1;
					it_q  <= it_q + 1'b1;
				end
				mke_pkg::S_PICK: begin
					// first candidate always taken; later ones only if strictly better
					if (cand_q == '0 || score_c > best_q) begin
						best_q       <= score_c;
						best_root_q  <= cand_root;
						best_minor_q <= cand_minor;
					end
					cand_q <= cand_q + 1'b1;
					num_q  <= '0;
				end
				mke_pkg::S_DONE: begin
					done_q      <= 1'b1;
					has_notes_q <= seen_q;
					root_q      <= seen_q ? best_root_q : 4'd0;
					is_minor_q  <= seen_q ? best_minor_q : 1'b0;
					score_q     <= seen_q ? best_q : 16'sd0;
					for (int i = 0; i < mke_pkg::NUM_CLASSES; i++) w_q[i] <= '0;
					seen_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign done      = done_q;
	assign root      = root_q;
	assign is_minor  = is_minor_q;
	assign has_notes = has_notes_q;
	assign score     = score_q;

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind |=> busy)
		else $error("end item did not start the key search");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> root < 4'd12)
		else $error("root out of range");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !has_notes |-> root == 4'd0 && !is_minor && score == 16'sd0)
		else $error("empty result not zero");
	a_weights_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !seen_q)
		else $error("note flag not cleared after result");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 1400;
	localparam longint WMAX = (64'd1 << mke_pkg::WEIGHT_BITS) - 1;

	localparam logic KIND_NOTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic [3:0]         root;
		logic               is_minor;
		logic               has_notes;
		logic signed [15:0] score;
	} key_t;

	typedef struct {
		logic        kind;
		logic [6:0]  pitch;
		logic [15:0] dur;
		bit          typed;
		key_t        want;
	} row_t;

	localparam longint KK_MAJ [12] = '{635, 223, 348, 233, 438, 409, 252, 519, 239, 366, 229, 288};
	localparam longint KK_MIN [12] = '{633, 268, 352, 538, 260, 353, 254, 475, 398, 269, 334, 317};

	logic clk, arst_n, start, kind;
	logic [6:0] pitch;
	logic [15:0] duration;
	logic busy, done, is_minor, has_notes;
	logic [3:0] root;
	logic signed [15:0] score;

	musical_key_estimator u_dut (.*);

	longint class_wt [12];
	bit     any_note;
	key_t   key_q [$];
	int     errors;
	int     n_items;
	int     idle_cnt;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > x)
			bt >>= 2;
		while (bt != 0) begin
			if (x >= res + bt) begin
				x = x - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic longint corr_score(input longint v [12], input longint sum_v,
			input bit minor, input int rt);
		longint sum_p, num, dw, dp, a, b, den, q;
		sum_p = 0; num = 0; dw = 0; dp = 0;
		for (int i = 0; i < 12; i++)
			sum_p += minor ? KK_MIN[i] : KK_MAJ[i];
		for (int i = 0; i < 12; i++) begin
			a = 12 * v[i] - sum_v;
			b = 12 * (minor ? KK_MIN[(i + 12 - rt) % 12] : KK_MAJ[(i + 12 - rt) % 12]) - sum_p;
			num += a * b;
			dw += a * a;
			dp += b * b;
		end
		if (dw == 0 || dp == 0)
			return 0;
		den = longint'(floor_root(dw) * floor_root(dp));
		q = (num * 32768) / den;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q;
	endfunction

	// apply one accepted item to the predicted weights; queue a key on end items
	function automatic void predict_item(input logic k, input logic [6:0] p, input logic [15:0] d);
		key_t r;
		longint v [12];
		longint mx, sum_v, best, c;
		int sh;
		if (k == KIND_NOTE) begin
			class_wt[p % 12] = class_wt[p % 12] + d > WMAX ? WMAX : class_wt[p % 12] + d;
			any_note = 1'b1;
			return;
		end
		r = '0;
		if (any_note) begin
			mx = 0; sh = 0; sum_v = 0; best = -65536;
			foreach (class_wt[i])
				if (class_wt[i] > mx) mx = class_wt[i];
			while ((mx >> sh) >= (64'd1 << mke_pkg::NORM_BITS))
				sh++;
			foreach (class_wt[i]) begin
				v[i] = class_wt[i] >> sh;
				sum_v += v[i];
			end
			for (int rt = 0; rt < 12; rt++)
				for (int m = 0; m < 2; m++) begin
					c = corr_score(v, sum_v, m[0], rt);
					if (c > best) begin
						best = c;
						r.root = 4'(rt);
						r.is_minor = m[0];
					end
				end
			r.has_notes = 1'b1;
			r.score = 16'(best);
		end
		key_q = {key_q, r};
		foreach (class_wt[i]) class_wt[i] = 0;
		any_note = 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		key_t w;
		if (done) begin
			if (key_q.size() == 0) begin
				report_mismatch("unexpected key", root, -1);
			end else begin
				w = key_q.pop_front();
				if (root !== w.root) report_mismatch("root", root, w.root);
				if (is_minor !== w.is_minor) report_mismatch("is_minor", is_minor, w.is_minor);
				if (has_notes !== w.has_notes) report_mismatch("has_notes", has_notes, w.has_notes);
				if (score !== w.score) report_mismatch("score", score, w.score);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	int gap_left, burst_left;

	// present an item and hold it until taken
	task automatic send(input logic k, input logic [6:0] p, input logic [15:0] d);
		if (burst_left == 0) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				repeat (gap_left) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		start <= 1'b1;
		kind <= k;
		pitch <= p;
		duration <= d;
		do @(posedge clk); while (busy);
		predict_item(k, p, d);
		n_items++;
	endtask

	task automatic send_typed(input row_t rw);
		send(rw.kind, rw.pitch, rw.dur);
		if (rw.typed)
			key_q[$] = rw.want;
	endtask

	row_t plan [$];
	int   seq_len, tonic;
	logic [6:0] pp;
	logic [15:0] dd;

	function automatic void add_row(input row_t rw);
		plan = {plan, rw};
	endfunction

	initial begin
		errors = 0; n_items = 0; idle_cnt = 0;
		burst_left = 0; gap_left = 0;
		foreach (class_wt[i]) class_wt[i] = 0;
		any_note = 1'b0;
		arst_n = 1'b0; start = 1'b0; kind = 1'b0; pitch = '0; duration = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, zero-duration note (flat weights), extremes, major triad, minor triad
		add_row('{KIND_END, 7'd0, 16'd0, 1'b1, key_t'{4'd0, 1'b0, 1'b0, 16'sd0}});
		add_row('{KIND_NOTE, 7'd0, 16'd0, 1'b0, '0});
		add_row('{KIND_END, 7'd0, 16'd0, 1'b1, key_t'{4'd0, 1'b0, 1'b1, 16'sd0}});
		add_row('{KIND_NOTE, 7'd127, 16'hFFFF, 1'b0, '0});
		add_row('{KIND_NOTE, 7'd0, 16'hFFFF, 1'b0, '0});
		add_row('{KIND_END, 7'd127, 16'hFFFF, 1'b0, '0});
		add_row('{KIND_NOTE, 7'd60, 16'h0400, 1'b0, '0});
		add_row('{KIND_NOTE, 7'd64, 16'h0200, 1'b0, '0});
		add_row('{KIND_NOTE, 7'd67, 16'h0300, 1'b0, '0});
		add_row('{KIND_END, 7'd0, 16'd0, 1'b0, '0});
		add_row('{KIND_NOTE, 7'd69, 16'h0001, 1'b0, '0});
		add_row('{KIND_NOTE, 7'd72, 16'h0001, 1'b0, '0});
		add_row('{KIND_NOTE, 7'd76, 16'h0002, 1'b0, '0});
		add_row('{KIND_END, 7'd0, 16'd0, 1'b0, '0});
		// one equal note per pitch class: flat weights
		for (int i = 0; i < 12; i++)
			add_row('{KIND_NOTE, 7'(60 + i), 16'h5555, 1'b0, '0});
		add_row('{KIND_END, 7'd0, 16'd0, 1'b1, key_t'{4'd0, 1'b0, 1'b1, 16'sd0}});
		foreach (plan[i])
			send_typed(plan[i]);

		// push one class well past the normalization range, plus a small second class
		for (int i = 0; i < 40; i++)
			send(KIND_NOTE, 7'd11, 16'hFFFF);
		send(KIND_NOTE, 7'd2, 16'h1234);
		send(KIND_END, 7'd0, 16'd0);

		// hold off until the block has drained
		start <= 1'b0;
		wait (key_q.size() == 0);
		@(posedge clk);

		while (n_items < 1700) begin
			seq_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
			tonic = $urandom_range(0, 11);
			for (int n = 0; n < seq_len; n++) begin
				case ($urandom_range(0, 3))
					0: pp = 7'($urandom_range(0, 127));
					default: pp = 7'(12 * $urandom_range(0, 9) + (tonic +
						(($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 4 : 7))) % 12);
				endcase
				case ($urandom_range(0, 9))
					0: dd = 16'd0;
					1: dd = 16'hFFFF;
					2: dd = 16'($urandom());
					default: dd = 16'($urandom_range(1, 16'h1000));
				endcase
				send(KIND_NOTE, pp, dd);
			end
			send(KIND_END, 7'($urandom_range(0, 127)), 16'($urandom()));
		end

		start <= 1'b0;
		wait (key_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
